// ----- hdl/gpsc_pkg.sv -----
// Shared types, constants and codes for the grip pressure stiffness and closure unit.
package gpsc_pkg;

    localparam int P_W        = 16;
    localparam int F_W        = 12;
    localparam int SUM_W      = F_W + 1;
    localparam int STF_W      = 11;
    localparam int CLS_W      = 16;
    localparam int MODE_W     = 3;
    localparam int SLIM_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DVD_W     = 29;
    localparam int DVS_W     = 15;
    localparam int QUO_W     = 16;
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int QSTF_W    = 13;
    localparam int KSTF_W    = 14;

    localparam int QUEUE_DEPTH_DEF = 2;

    // floor(t/50) == (t*1311) >> 16 for every 12-bit t
    localparam int          RECIP_W     = 11;
    localparam int          RECIP_SHIFT = 16;
    localparam int          PROD_W      = F_W + RECIP_W;
    localparam int          FALL_W      = PROD_W - RECIP_SHIFT;
    localparam int          RISE_W      = FALL_W - 2;
    localparam logic [RECIP_W-1:0] RECIP_50 = 11'd1311;

    localparam logic [STF_W-1:0] STF_SAT_MAX = 11'h7FF;
    localparam logic [STF_W-1:0] STF_HELD_RST = 11'd100;

    localparam logic [MODE_W-1:0] STF_MODE_MAX_A  = 3'd1;
    localparam logic [MODE_W-1:0] STF_MODE_MAX_B  = 3'd2;
    localparam logic [MODE_W-1:0] STF_MODE_MIN_A  = 3'd3;
    localparam logic [MODE_W-1:0] STF_MODE_MIN_B  = 3'd4;
    localparam logic [MODE_W-1:0] STF_MODE_PROP_A = 3'd5;
    localparam logic [MODE_W-1:0] STF_MODE_PROP_B = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FSCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STF_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STF_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLS_BASE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLS_GAIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLS_MAX  = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [F_W-1:0]    threshold;
        logic [F_W-1:0]    full_scale;
        logic [SLIM_W-1:0] stf_min;
        logic [SLIM_W-1:0] stf_max;
        logic [CLS_W-1:0]  cls_base;
        logic [CLS_W-1:0]  cls_gain;
        logic [CLS_W-1:0]  cls_max;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        mode:       3'd1,
        threshold:  12'd500,
        full_scale: 12'd3000,
        stf_min:    10'd100,
        stf_max:    10'd500,
        cls_base:   16'd8645,
        cls_gain:   16'd28500,
        cls_max:    16'd12350
    };

    typedef struct packed {
        logic [F_W-1:0]   f1;
        logic [F_W-1:0]   f2;
        logic [SUM_W-1:0] sum;
        logic             hs;
        logic             stf_upd;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV_S,
        BK_DIV_C,
        BK_OUT
    } t_back_state;

endpackage

// ----- hdl/gpsc_in_if.sv -----
// Input channel: raw grip pressure pair with valid/ready handshake.
interface gpsc_in_if;
    import gpsc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [P_W-1:0] pressure_1;
    logic signed [P_W-1:0] pressure_2;

    modport source (output valid, output pressure_1, output pressure_2, input ready);
    modport sink   (input valid, input pressure_1, input pressure_2, output ready);
endinterface

// ----- hdl/gpsc_out_if.sv -----
// Output channel: filtered pressures, stiffness and closure with valid/ready handshake.
interface gpsc_out_if;
    import gpsc_pkg::*;

    logic             valid;
    logic             ready;
    logic [F_W-1:0]   filtered_1;
    logic [F_W-1:0]   filtered_2;
    logic [STF_W-1:0] stiffness;
    logic [CLS_W-1:0] closure;
    logic             handshake_present;

    modport source (output valid, output filtered_1, output filtered_2, output stiffness,
                    output closure, output handshake_present, input ready);
    modport sink   (input valid, input filtered_1, input filtered_2, input stiffness,
                    input closure, input handshake_present, output ready);
endinterface

// ----- hdl/gpsc_front.sv -----
// Front end: input register, per-channel rate limiter and clamp, item classification.
module gpsc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gpsc_pkg::t_cfg   i_cfg,
    gpsc_in_if.sink          i_in,
    input  gpsc_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output gpsc_pkg::t_item  o_item
);
    import gpsc_pkg::*;

    logic                  r_hold_valid;
    logic signed [P_W-1:0] r_p1;
    logic signed [P_W-1:0] r_p2;
    logic [F_W-1:0]        r_prev1;
    logic [F_W-1:0]        r_prev2;

    logic [PROD_W-1:0] w_prod;
    logic [FALL_W-1:0] w_fall;
    logic [RISE_W-1:0] w_rise;
    logic [F_W-1:0]    w_f1;
    logic [F_W-1:0]    w_f2;

    function automatic logic [F_W-1:0] f_filter(
        input logic signed [P_W-1:0] a_in,
        input logic [F_W-1:0]        prev,
        input logic [F_W-1:0]        thr,
        input logic [FALL_W-1:0]     fall,
        input logic [RISE_W-1:0]     rise,
        input logic [F_W-1:0]        fs
    );
        logic signed [P_W+1:0] a;
        logic signed [P_W+1:0] p;
        logic signed [P_W+1:0] t;
        logic signed [P_W+1:0] fl;
        logic signed [P_W+1:0] rs;
        logic signed [P_W+1:0] d;
        logic signed [P_W+1:0] ad;
        logic [F_W-1:0]        res;
        a  = {{2{a_in[P_W-1]}}, a_in};
        p  = $signed({{(P_W+2-F_W){1'b0}}, prev});
        t  = $signed({{(P_W+2-F_W){1'b0}}, thr});
        fl = $signed({{(P_W+2-FALL_W){1'b0}}, fall});
        rs = $signed({{(P_W+2-RISE_W){1'b0}}, rise});
        d  = a - p;
        ad = d[P_W+1] ? -d : d;
        if (ad > t) begin
            if (d[P_W+1]) begin
                a = p - fl;
            end else begin
                a = p + rs;
            end
        end
        d  = a - p;
        ad = d[P_W+1] ? -d : d;
        if (ad < rs) begin
            a = p;
        end
        if (a[P_W+1]) begin
            res = '0;
        end else if (a > $signed({{(P_W+2-F_W){1'b0}}, fs})) begin
            res = fs;
        end else begin
            res = a[F_W-1:0];
        end
        return res;
    endfunction

    assign w_prod = PROD_W'(i_cfg.threshold) * PROD_W'(RECIP_50);
    assign w_fall = w_prod[PROD_W-1:RECIP_SHIFT];
    assign w_rise = w_fall[FALL_W-1:2];

    assign w_f1 = f_filter(r_p1, r_prev1, i_cfg.threshold, w_fall, w_rise, i_cfg.full_scale);
    assign w_f2 = f_filter(r_p2, r_prev2, i_cfg.threshold, w_fall, w_rise, i_cfg.full_scale);

    assign o_push         = r_hold_valid && !i_q_stat.full;
    assign o_item.f1      = w_f1;
    assign o_item.f2      = w_f2;
    assign o_item.sum     = {1'b0, w_f1} + {1'b0, w_f2};
    assign o_item.hs      = w_f1 > i_cfg.threshold;
    assign o_item.stf_upd = (w_f1 > i_cfg.threshold) && (w_f2 > i_cfg.threshold);

    assign i_in.ready = !r_hold_valid || o_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_prev1      <= '0;
            r_prev2      <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_hold_valid <= 1'b1;
                r_p1         <= i_in.pressure_1;
                r_p2         <= i_in.pressure_2;
            end else if (o_push) begin
                r_hold_valid <= 1'b0;
            end
            if (o_push) begin
                r_prev1 <= w_f1;
                r_prev2 <= w_f2;
            end
        end
    end

endmodule

// ----- hdl/gpsc_queue.sv -----
// Small register queue between front end and back end.
module gpsc_queue #(
    parameter int DEPTH = gpsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gpsc_pkg::t_item   i_item,
    input  logic              i_pop,
    output gpsc_pkg::t_item   o_item,
    output gpsc_pkg::t_q_stat o_stat
);
    import gpsc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_stat.full  = r_cnt == CNT_W'(DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign o_item       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hdl/gpsc_div.sv -----
// Restoring unsigned divider, two quotient bits per cycle.
module gpsc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gpsc_pkg::DVD_W-1:0]  i_dividend,
    input  logic [gpsc_pkg::DVS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [gpsc_pkg::QUO_W-1:0]  o_quotient,
    output logic                        o_rem_nz
);
    import gpsc_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [QUO_W-1:0]  r_low;
    logic [QUO_W-1:0]  r_quo;

    logic [DVS_W:0]   w_t0;
    logic [DVS_W:0]   w_t1;
    logic             w_ge0;
    logic             w_ge1;
    logic [DVS_W-1:0] w_rem0;
    logic [DVS_W-1:0] w_rem1;

    always_comb begin
        w_t0   = {r_rem, r_low[QUO_W-1]};
        w_ge0  = w_t0 >= {1'b0, r_dvs};
        w_rem0 = w_ge0 ? DVS_W'(w_t0 - {1'b0, r_dvs}) : w_t0[DVS_W-1:0];
        w_t1   = {w_rem0, r_low[QUO_W-2]};
        w_ge1  = w_t1 >= {1'b0, r_dvs};
        w_rem1 = w_ge1 ? DVS_W'(w_t1 - {1'b0, r_dvs}) : w_t1[DVS_W-1:0];
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
    assign o_rem_nz   = r_rem != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= DVS_W'(i_dividend >> QUO_W);
                r_low  <= i_dividend[QUO_W-1:0];
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_rem1;
                r_low <= r_low << 2;
                r_quo <= {r_quo[QUO_W-3:0], w_ge0, w_ge1};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hdl/gpsc_back.sv -----
// Back end: stiffness and closure sequencer with shared divider and output register.
module gpsc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gpsc_pkg::t_cfg    i_cfg,
    input  gpsc_pkg::t_item   i_item,
    input  gpsc_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    gpsc_out_if.source        o_out
);
    import gpsc_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    t_item             r_item;
    logic              r_neg;
    logic [DVD_W-1:0]  r_num_cls;
    logic [QSTF_W-1:0] r_q_stf;
    logic              r_rnz_stf;
    logic [QUO_W-1:0]  r_q_cls;
    logic [STF_W-1:0]  r_held;
    logic [STF_W-1:0]  n_held;

    logic             r_out_valid;
    logic [F_W-1:0]   r_out_f1;
    logic [F_W-1:0]   r_out_f2;
    logic [STF_W-1:0] r_out_stf;
    logic [CLS_W-1:0] r_out_cls;
    logic             r_out_hs;

    logic              w_out_free;
    logic              w_load;
    logic              w_start;
    logic [DVD_W-1:0]  w_dvd;
    logic [DVS_W-1:0]  w_dvs;
    logic              w_done;
    logic [QUO_W-1:0]  w_quo;
    logic              w_rem_nz;
    logic [SLIM_W:0]   w_diff;
    logic [SLIM_W-1:0] w_absd;
    logic [SUM_W-1:0]  w_absd7;
    logic [DVD_W-1:0]  w_mul_stf;
    logic [DVD_W-1:0]  w_mul_cls;
    logic              w_fs_zero;
    logic [KSTF_W-1:0] w_q;
    logic [KSTF_W-1:0] w_k;
    logic [STF_W-1:0]  w_k_sat;
    logic [CLS_W:0]    w_c;
    logic [CLS_W-1:0]  w_c_cl;
    logic [CLS_W-1:0]  w_closure;

    gpsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quotient (w_quo),
        .o_rem_nz   (w_rem_nz)
    );

    assign w_fs_zero = i_cfg.full_scale == '0;
    assign w_diff    = {1'b0, i_cfg.stf_max} - {1'b0, i_cfg.stf_min};
    assign w_absd    = w_diff[SLIM_W] ? SLIM_W'(-w_diff) : w_diff[SLIM_W-1:0];
    assign w_absd7   = ({3'b000, w_absd} << 3) - {3'b000, w_absd};
    assign w_mul_stf = DVD_W'(w_absd7) * DVD_W'(r_item.sum);
    assign w_mul_cls = DVD_W'(i_cfg.cls_gain) * DVD_W'(r_item.sum);

    assign w_dvd = (r_state == BK_MUL) ? w_mul_stf : r_num_cls;
    assign w_dvs = (r_state == BK_MUL) ? {i_cfg.full_scale, 3'b000}
                                       : {2'b00, i_cfg.full_scale, 1'b0};

    // floor of a negative quotient steps down when the remainder is nonzero
    always_comb begin
        w_q = {1'b0, r_q_stf};
        if (r_neg) begin
            w_q = KSTF_W'(-w_q) - KSTF_W'(r_rnz_stf);
        end
        w_k = {{(KSTF_W-SLIM_W){1'b0}}, i_cfg.stf_min};
        if (!w_fs_zero) begin
            w_k = w_k + w_q;
        end
        if (w_k[KSTF_W-1]) begin
            w_k_sat = '0;
        end else if (w_k[KSTF_W-2:STF_W] != '0) begin
            w_k_sat = STF_SAT_MAX;
        end else begin
            w_k_sat = w_k[STF_W-1:0];
        end
    end

    always_comb begin
        unique case (i_cfg.mode) inside
            STF_MODE_MAX_A, STF_MODE_MAX_B: n_held = STF_W'(i_cfg.stf_max);
            STF_MODE_MIN_A, STF_MODE_MIN_B: n_held = STF_W'(i_cfg.stf_min);
            STF_MODE_PROP_A, STF_MODE_PROP_B: n_held = r_item.stf_upd ? w_k_sat : r_held;
            default: n_held = r_held;
        endcase
    end

    always_comb begin
        w_c = {1'b0, i_cfg.cls_base};
        if (!w_fs_zero) begin
            w_c = w_c + {1'b0, r_q_cls};
        end
        w_c_cl    = (w_c > {1'b0, i_cfg.cls_max}) ? i_cfg.cls_max : w_c[CLS_W-1:0];
        w_closure = r_item.hs ? w_c_cl : '0;
    end

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_load     = (r_state == BK_OUT) && w_out_free;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_start = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                w_start = 1'b1;
                n_state = BK_DIV_S;
            end
            BK_DIV_S: begin
                if (w_done) begin
                    w_start = 1'b1;
                    n_state = BK_DIV_C;
                end
            end
            BK_DIV_C: begin
                if (w_done) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == BK_MUL) begin
            r_neg     <= w_diff[SLIM_W];
            r_num_cls <= w_mul_cls;
        end
        if (r_state == BK_DIV_S && w_done) begin
            r_q_stf   <= w_quo[QSTF_W-1:0];
            r_rnz_stf <= w_rem_nz;
        end
        if (r_state == BK_DIV_C && w_done) begin
            r_q_cls <= w_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= STF_HELD_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_held      <= n_held;
                r_out_valid <= 1'b1;
                r_out_f1    <= r_item.f1;
                r_out_f2    <= r_item.f2;
                r_out_stf   <= n_held;
                r_out_cls   <= w_closure;
                r_out_hs    <= r_item.hs;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.filtered_1        = r_out_f1;
    assign o_out.filtered_2        = r_out_f2;
    assign o_out.stiffness         = r_out_stf;
    assign o_out.closure           = r_out_cls;
    assign o_out.handshake_present = r_out_hs;

endmodule

// ----- hdl/grip_pressure_stiffness_closure_unit.sv -----
// Top level of the grip pressure stiffness and closure unit: config registers and datapath.
//
//  channel  dir  handshake            payload
//  i_in     in   valid / ready        pressure_1, pressure_2 (signed 16)
//  o_out    out  valid / ready        filtered_1, filtered_2, stiffness, closure,
//                                     handshake_present
//  cfg      in   i_cfg_we             i_cfg_idx (3), i_cfg_data (16)
//
//  The back end takes a new item only after loading the last one into the output
//  register, and so sets the rate: pop, multiply, two 8-step divisions on the shared
//  two-bit-per-cycle divider, each ending on its done strobe, output load.
//  The front end filters the next item while the back end divides.
//  Reset is synchronous; it clears state and filter history and sets held stiffness to its reset value.
//  A stalled output holds its register; the queue and input register absorb stalls.
module grip_pressure_stiffness_closure_unit #(
    parameter int QUEUE_DEPTH = gpsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gpsc_in_if.sink                         i_in,
    gpsc_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [gpsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gpsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gpsc_pkg::*;

    t_cfg    r_cfg;
    logic    w_push;
    logic    w_pop;
    t_item   w_push_item;
    t_item   w_pop_item;
    t_q_stat w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_MODE:     r_cfg.mode       <= i_cfg_data[MODE_W-1:0];
                CFG_IDX_THRESH:   r_cfg.threshold  <= i_cfg_data[F_W-1:0];
                CFG_IDX_FSCALE:   r_cfg.full_scale <= i_cfg_data[F_W-1:0];
                CFG_IDX_STF_MIN:  r_cfg.stf_min    <= i_cfg_data[SLIM_W-1:0];
                CFG_IDX_STF_MAX:  r_cfg.stf_max    <= i_cfg_data[SLIM_W-1:0];
                CFG_IDX_CLS_BASE: r_cfg.cls_base   <= i_cfg_data[CLS_W-1:0];
                CFG_IDX_CLS_GAIN: r_cfg.cls_gain   <= i_cfg_data[CLS_W-1:0];
                CFG_IDX_CLS_MAX:  r_cfg.cls_max    <= i_cfg_data[CLS_W-1:0];
                default:          r_cfg            <= r_cfg;
            endcase
        end
    end

    gpsc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    gpsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_pop_item),
        .o_stat  (w_q_stat)
    );

    gpsc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (w_pop_item),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    a_q_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue reports full and empty together");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

    a_closure_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.handshake_present) |-> (o_out.closure == '0))
        else $error("closure without handshake");

    a_filtered_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.filtered_1 <= r_cfg.full_scale &&
                         o_out.filtered_2 <= r_cfg.full_scale))
        else $error("filtered pressure above full scale");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the grip pressure stiffness and closure unit.
`timescale 1ns / 100ps

import gpsc_pkg::*;

typedef struct packed {
    logic [F_W-1:0]   filtered_1;
    logic [F_W-1:0]   filtered_2;
    logic [STF_W-1:0] stiffness;
    logic [CLS_W-1:0] closure;
    logic             handshake_present;
} t_grip_command;

class grip_scoreboard;
    t_cfg             regs;
    logic [F_W-1:0]   last_1;
    logic [F_W-1:0]   last_2;
    logic [STF_W-1:0] held_stiffness;
    t_grip_command    expected_cmds[$];
    int               mismatches;

    function new();
        regs           = CFG_RST;
        last_1         = '0;
        last_2         = '0;
        held_stiffness = STF_HELD_RST;
        mismatches     = 0;
    endfunction

    function int pending();
        return expected_cmds.size();
    endfunction

    function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IDX_MODE:     regs.mode       = data[MODE_W-1:0];
            CFG_IDX_THRESH:   regs.threshold  = data[F_W-1:0];
            CFG_IDX_FSCALE:   regs.full_scale = data[F_W-1:0];
            CFG_IDX_STF_MIN:  regs.stf_min    = data[SLIM_W-1:0];
            CFG_IDX_STF_MAX:  regs.stf_max    = data[SLIM_W-1:0];
            CFG_IDX_CLS_BASE: regs.cls_base   = data[CLS_W-1:0];
            CFG_IDX_CLS_GAIN: regs.cls_gain   = data[CLS_W-1:0];
            CFG_IDX_CLS_MAX:  regs.cls_max    = data[CLS_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [F_W-1:0] rate_limit(logic signed [P_W-1:0] raw, logic [F_W-1:0] last);
        int a, p, thr, fs, fall_step, rise_step, gap;
        a         = int'(raw);
        p         = int'(last);
        thr       = int'(regs.threshold);
        fs        = int'(regs.full_scale);
        fall_step = thr / 50;
        rise_step = thr / 200;
        gap       = (a > p) ? a - p : p - a;
        if (gap > thr) begin
            if (p > a)
                a = p - fall_step;
            else if (p < a)
                a = p + rise_step;
        end
        gap = (a > p) ? a - p : p - a;
        if (gap < rise_step)
            a = p;
        if (a < 0)
            a = 0;
        if (a > fs)
            a = fs;
        return a[F_W-1:0];
    endfunction

    function void note_sample(logic signed [P_W-1:0] raw_1, logic signed [P_W-1:0] raw_2);
        t_grip_command cmd;
        int            sum, k, diff, num, den, q;
        int unsigned   c;
        cmd.filtered_1 = rate_limit(raw_1, last_1);
        cmd.filtered_2 = rate_limit(raw_2, last_2);
        last_1         = cmd.filtered_1;
        last_2         = cmd.filtered_2;
        sum            = int'(cmd.filtered_1) + int'(cmd.filtered_2);

        case (regs.mode)
            STF_MODE_MAX_A, STF_MODE_MAX_B: held_stiffness = STF_W'(regs.stf_max);
            STF_MODE_MIN_A, STF_MODE_MIN_B: held_stiffness = STF_W'(regs.stf_min);
            STF_MODE_PROP_A, STF_MODE_PROP_B: begin
                if (cmd.filtered_1 > regs.threshold && cmd.filtered_2 > regs.threshold) begin
                    k = int'(regs.stf_min);
                    if (regs.full_scale != 0) begin
                        diff = int'(regs.stf_max) - int'(regs.stf_min);
                        num  = 7 * diff * sum;
                        den  = 8 * int'(regs.full_scale);
                        q    = num / den;
                        if (num % den != 0 && num < 0)
                            q = q - 1;
                        k = k + q;
                    end
                    if (k < 0)
                        k = 0;
                    if (k > 2047)
                        k = 2047;
                    held_stiffness = k[STF_W-1:0];
                end
            end
            default: ;
        endcase
        cmd.stiffness = held_stiffness;

        cmd.closure           = '0;
        cmd.handshake_present = 1'b0;
        if (cmd.filtered_1 > regs.threshold) begin
            c = 32'(regs.cls_base);
            if (regs.full_scale != 0)
                c = c + (int'(regs.cls_gain) * sum) / (2 * int'(regs.full_scale));
            if (c > 32'(regs.cls_max))
                c = 32'(regs.cls_max);
            cmd.closure           = c[CLS_W-1:0];
            cmd.handshake_present = 1'b1;
        end
        expected_cmds.insert(expected_cmds.size(), cmd);
    endfunction

    function void check_command(t_grip_command got);
        t_grip_command want;
        if (expected_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: f1 %0d f2 %0d stf %0d cls %0d hs %0d",
                         got.filtered_1, got.filtered_2, got.stiffness, got.closure,
                         got.handshake_present);
            return;
        end
        want = expected_cmds.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $write("mismatch (expected/actual): f1 %0d/%0d f2 %0d/%0d ",
                       want.filtered_1, got.filtered_1, want.filtered_2, got.filtered_2);
                $display("stf %0d/%0d cls %0d/%0d hs %0d/%0d",
                         want.stiffness, got.stiffness, want.closure, got.closure,
                         want.handshake_present, got.handshake_present);
            end
        end
    endfunction
endclass

module tb_top;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIRECTED_N  = 20;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    localparam int DIRECTED_1 [DIRECTED_N] = '{-32768, 32767, 0, -1, 400, 900, 1401, 1403,
        1900, 2400, 2900, 3500, 4095, 32767, 0, -32768, 2000, 2500, 499, 501};
    localparam int DIRECTED_2 [DIRECTED_N] = '{32767, -32768, 0, -1, 10, 500, 501, 1001,
        1502, 1000, 2003, 2503, 3003, 3600, -1, 0, 2950, 2900, 3000, 2990};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    tx_idle_pct;
    int                    rx_idle_pct;
    int unsigned           cycles = 0;

    grip_scoreboard sb = new();

    gpsc_in_if  in_ch ();
    gpsc_out_if out_ch ();

    grip_pressure_stiffness_closure_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_sample(in_ch.pressure_1, in_ch.pressure_2);
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_command(t_grip_command'{out_ch.filtered_1, out_ch.filtered_2,
                out_ch.stiffness, out_ch.closure, out_ch.handshake_present});
    end

    // call at a falling edge; returns at the edge that accepts the transaction
    task automatic drive_item(int raw_1, int raw_2);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.pressure_1 <= P_W'(raw_1);
        in_ch.pressure_2 <= P_W'(raw_2);
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // drop valid and hold until every expected result has come back
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value, int width);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        if ($urandom_range(0, 1))
            data = data | (CFG_DATA_W'($urandom) << width);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_cfg(idx, data);
    endtask

    task automatic load_setting(t_cfg s);
        write_reg(CFG_IDX_MODE, 32'(s.mode), MODE_W);
        write_reg(CFG_IDX_THRESH, 32'(s.threshold), F_W);
        write_reg(CFG_IDX_FSCALE, 32'(s.full_scale), F_W);
        write_reg(CFG_IDX_STF_MIN, 32'(s.stf_min), SLIM_W);
        write_reg(CFG_IDX_STF_MAX, 32'(s.stf_max), SLIM_W);
        write_reg(CFG_IDX_CLS_BASE, 32'(s.cls_base), CLS_W);
        write_reg(CFG_IDX_CLS_GAIN, 32'(s.cls_gain), CLS_W);
        write_reg(CFG_IDX_CLS_MAX, 32'(s.cls_max), CLS_W);
    endtask

    function automatic t_cfg setting_for(int phase);
        t_cfg s;
        int   fs;
        s = CFG_RST;
        case (phase)
            1: s.mode = STF_MODE_PROP_A;
            2: s = '{STF_MODE_MIN_A, 12'd40, 12'd4095, 10'd1023, 10'd0,
                     16'd65535, 16'd65535, 16'd65535};
            3: s = '{STF_MODE_PROP_B, 12'd100, 12'd4095, 10'd1023, 10'd0,
                     16'd0, 16'd65535, 16'd40000};
            4: s = '{MODE_UNUSED_LO, 12'd4095, 12'd1, 10'd0, 10'd1023,
                     16'd0, 16'd0, 16'd0};
            5: s = '{MODE_UNUSED_HI, 12'd0, 12'd0, 10'd0, 10'd0,
                     16'd65535, 16'd0, 16'd65535};
            6: s = '{STF_MODE_MAX_B, 12'd12, 12'd2000, 10'd512, 10'd511,
                     16'd1, 16'd1, 16'd1};
            7: s = '{STF_MODE_MIN_B, 12'd300, 12'd2500, 10'd20, 10'd1000,
                     16'd100, 16'd60000, 16'd65535};
            default: begin
                fs           = $urandom_range(1, 4095);
                s.full_scale = F_W'(fs);
                s.threshold  = ($urandom_range(0, 3) == 0) ? F_W'($urandom)
                                                           : F_W'($urandom_range(0, fs / 3));
                if ($urandom_range(0, 3) == 0)
                    s.mode = MODE_W'($urandom);
                else
                    s.mode = $urandom_range(0, 1) ? STF_MODE_PROP_A : STF_MODE_PROP_B;
                s.stf_min  = SLIM_W'($urandom);
                s.stf_max  = SLIM_W'($urandom);
                s.cls_base = CLS_W'($urandom);
                s.cls_gain = CLS_W'($urandom);
                s.cls_max  = CLS_W'($urandom);
            end
        endcase
        return s;
    endfunction

    // mostly steps within the threshold of the last value, so the filter tracks
    function automatic int pick_raw(int last, int thr, int fs);
        int raw, reach, r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            reach = $urandom_range(0, 1) ? thr / 2 : thr;
            raw   = last - reach + int'($urandom_range(0, reach + thr + 1));
        end else if (r < 75) begin
            raw = $urandom_range(0, fs + fs / 8 + 1);
        end else if (r < 90) begin
            raw = int'($signed(P_W'($urandom)));
        end else begin
            case ($urandom_range(0, 7))
                0:       raw = -32768;
                1:       raw = 32767;
                2:       raw = 0;
                3:       raw = -1;
                4:       raw = thr;
                5:       raw = thr + 1;
                6:       raw = fs;
                default: raw = last - thr - 1;
            endcase
        end
        if (raw > 32767)
            raw = 32767;
        if (raw < -32768)
            raw = -32768;
        return raw;
    endfunction

    initial begin
        int phase, n, items, raw_1, raw_2;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= '0;
        cfg_data         <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.pressure_1 <= '0;
        in_ch.pressure_2 <= '0;
        tx_idle_pct      = 22;
        rx_idle_pct      = 81;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < DIRECTED_N; n++) begin
            @(negedge clk);
            drive_item(DIRECTED_1[n], DIRECTED_2[n]);
        end

        for (phase = 1; phase <= 10; phase++) begin
            drain();
            if (phase <= 3) begin
                tx_idle_pct = 22;
                rx_idle_pct = 81;
            end else if (phase <= 6) begin
                tx_idle_pct = 81;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            load_setting(setting_for(phase));
            items = (phase == 4 || phase == 5) ? 60 : 160;
            for (n = 0; n < items; n++) begin
                if (n == items / 2 && phase % 3 == 1)
                    drain();
                @(negedge clk);
                raw_1 = pick_raw(int'(sb.last_1), int'(sb.regs.threshold),
                                 int'(sb.regs.full_scale));
                raw_2 = pick_raw(int'(sb.last_2), int'(sb.regs.threshold),
                                 int'(sb.regs.full_scale));
                drive_item(raw_1, raw_2);
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ----- grip_pressure_stiffness_closure_unit.f -----
hdl/gpsc_pkg.sv
hdl/gpsc_in_if.sv
hdl/gpsc_out_if.sv
hdl/gpsc_front.sv
hdl/gpsc_queue.sv
hdl/gpsc_div.sv
hdl/gpsc_back.sv
hdl/grip_pressure_stiffness_closure_unit.sv
tb/tb_top.sv
